### rtl/core/cshit_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cshit_pkg
// Shared widths and constants for the circle / segment hit test core.
// ----------------------------------------------------------------------------
package cshit_pkg;
    localparam int CW       = 32;          // coordinate width
    localparam int DW       = CW + 1;      // coordinate difference width
    localparam int RAD_W    = 31;
    localparam int TOL_W    = 16;
    localparam int SQ_W     = 2 * DW;      // square of a difference
    localparam int SUM_W    = SQ_W + 1;    // sum of two squares
    localparam int DOT_W    = SUM_W + 1;   // signed dot / cross product
    localparam int R2_W     = 2 * RAD_W;
    localparam int T2_W     = 2 * TOL_W;
    localparam int IN_W     = 224;         // 6*32 + 31, padded to bytes
    localparam int OUT_W    = 8;
    localparam int MUL_LAT  = 3;           // cycles through cshit_mul
    localparam logic [TOL_W-1:0] TOL_RST = 16'd6554;
endpackage
`default_nettype wire

### rtl/core/cshit_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cshit_mul
// Unsigned pipelined multiplier: 32x32 partial products, row sums, final sum.
// Each of these steps is registered; the pipeline advances when i_en is high.
// ----------------------------------------------------------------------------
module cshit_mul #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [AW-1:0]    i_a,
    input  wire logic [BW-1:0]    i_b,
    output logic      [AW+BW-1:0] o_p
);
    localparam int NA  = (AW + 31) / 32;
    localparam int NB  = (BW + 31) / 32;
    localparam int AXW = NA * 32;
    localparam int BXW = NB * 32;
    localparam int PW  = AW + BW;

    logic [AXW-1:0] a_x;
    logic [BXW-1:0] b_x;
    logic [63:0]    r_pp  [NA][NB];
    logic [PW-1:0]  n_row [NA];
    logic [PW-1:0]  r_row [NA];
    logic [PW-1:0]  n_p;
    logic [PW-1:0]  r_p;

    assign a_x = AXW'(i_a);
    assign b_x = BXW'(i_b);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    r_pp[i][j] <= a_x[32*i +: 32] * b_x[32*j +: 32];
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < NA; i++) begin
            n_row[i] = '0;
            for (int j = 0; j < NB; j++) begin
                n_row[i] = n_row[i] + (PW'(r_pp[i][j]) << (32 * j));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_row <= n_row;
        end
    end

    always_comb begin
        n_p = '0;
        for (int i = 0; i < NA; i++) begin
            n_p = n_p + (r_row[i] << (32 * i));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;
endmodule
`default_nettype wire

### rtl/core/cshit_dly.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cshit_dly
// Control delay line matching the multiplier latency; cleared by reset.
// ----------------------------------------------------------------------------
module cshit_dly #(
    parameter int W = 1,
    parameter int L = 3
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_en,
    input  wire logic [W-1:0] i_d,
    output logic      [W-1:0] o_d
);
    logic [W-1:0] r_sh [L];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < L; k++) begin
                r_sh[k] <= '0;
            end
        end else if (i_en) begin
            r_sh[0] <= i_d;
            for (int k = 1; k < L; k++) begin
                r_sh[k] <= r_sh[k-1];
            end
        end
    end

    assign o_d = r_sh[L-1];
endmodule
`default_nettype wire

### rtl/core/circle_segment_hit_test_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// circle_segment_hit_test_core
// Exact Q16.16 circle versus line segment hit test, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one query beat per cycle unless the output stalls, and returns one hit
// beat per query, in order, after an input difference stage, two multiplier banks
// (squares and dot/cross products, then the final squared comparisons) with a sum
// stage and an overshoot stage between them, and an output register. The pipeline
// advances as a whole; it holds only while a result sits in the output register
// unclaimed. The tolerance register is written through the cfg channel, which is
// always ready.
module circle_segment_hit_test_core (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    // seg_ax, seg_ay, seg_bx, seg_by, center_x, center_y, circle_radius, pad
    input  wire logic [cshit_pkg::IN_W-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    // hit, pad
    output logic [cshit_pkg::OUT_W-1:0]   m_axis_tdata,
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [cshit_pkg::TOL_W-1:0] i_cfg_data
);
    import cshit_pkg::*;

    logic en;
    logic [TOL_W-1:0] r_tol;

    // ---------------- config
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RST;
        end else if (i_cfg_valid) begin
            r_tol <= i_cfg_data;
        end
    end

    // ---------------- stage 0: differences
    logic signed [CW-1:0] ax, ay, bx, by, cx, cy;
    logic r_v0;
    logic signed [DW-1:0] r_pax, r_pay, r_pbx, r_pby, r_dx, r_dy;
    logic [RAD_W-1:0] r_rad;

    assign ax = s_axis_tdata[31:0];
    assign ay = s_axis_tdata[63:32];
    assign bx = s_axis_tdata[95:64];
    assign by = s_axis_tdata[127:96];
    assign cx = s_axis_tdata[159:128];
    assign cy = s_axis_tdata[191:160];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pax <= DW'(cx) - DW'(ax);
            r_pay <= DW'(cy) - DW'(ay);
            r_pbx <= DW'(cx) - DW'(bx);
            r_pby <= DW'(cy) - DW'(by);
            r_dx  <= DW'(bx) - DW'(ax);
            r_dy  <= DW'(by) - DW'(ay);
            r_rad <= s_axis_tdata[222:192];
        end
    end

    // magnitudes; a difference never exceeds 2^32 in size
    logic [DW-1:0] m_pax, m_pay, m_pbx, m_pby, m_dx, m_dy;
    assign m_pax = r_pax[DW-1] ? DW'(-r_pax) : DW'(r_pax);
    assign m_pay = r_pay[DW-1] ? DW'(-r_pay) : DW'(r_pay);
    assign m_pbx = r_pbx[DW-1] ? DW'(-r_pbx) : DW'(r_pbx);
    assign m_pby = r_pby[DW-1] ? DW'(-r_pby) : DW'(r_pby);
    assign m_dx  = r_dx[DW-1]  ? DW'(-r_dx)  : DW'(r_dx);
    assign m_dy  = r_dy[DW-1]  ? DW'(-r_dy)  : DW'(r_dy);

    // ---------------- bank 1
    logic [SQ_W-1:0] sq_pax, sq_pay, sq_pbx, sq_pby, sq_dx, sq_dy;
    logic [SQ_W-1:0] p_xdx, p_ydy, p_xdy, p_ydx;
    logic [R2_W-1:0] r2_m;
    logic [T2_W-1:0] t2_m;
    logic [4:0] sb1_in, sb1_out;

    cshit_mul #(.AW(DW), .BW(DW)) u_sq0 (.i_clk, .i_en(en), .i_a(m_pax), .i_b(m_pax), .o_p(sq_pax));
    cshit_mul #(.AW(DW), .BW(DW)) u_sq1 (.i_clk, .i_en(en), .i_a(m_pay), .i_b(m_pay), .o_p(sq_pay));
    cshit_mul #(.AW(DW), .BW(DW)) u_sq2 (.i_clk, .i_en(en), .i_a(m_pbx), .i_b(m_pbx), .o_p(sq_pbx));
    cshit_mul #(.AW(DW), .BW(DW)) u_sq3 (.i_clk, .i_en(en), .i_a(m_pby), .i_b(m_pby), .o_p(sq_pby));
    cshit_mul #(.AW(DW), .BW(DW)) u_sq4 (.i_clk, .i_en(en), .i_a(m_dx),  .i_b(m_dx),  .o_p(sq_dx));
    cshit_mul #(.AW(DW), .BW(DW)) u_sq5 (.i_clk, .i_en(en), .i_a(m_dy),  .i_b(m_dy),  .o_p(sq_dy));
    cshit_mul #(.AW(DW), .BW(DW)) u_pr0 (.i_clk, .i_en(en), .i_a(m_pax), .i_b(m_dx),  .o_p(p_xdx));
    cshit_mul #(.AW(DW), .BW(DW)) u_pr1 (.i_clk, .i_en(en), .i_a(m_pay), .i_b(m_dy),  .o_p(p_ydy));
    cshit_mul #(.AW(DW), .BW(DW)) u_pr2 (.i_clk, .i_en(en), .i_a(m_pax), .i_b(m_dy),  .o_p(p_xdy));
    cshit_mul #(.AW(DW), .BW(DW)) u_pr3 (.i_clk, .i_en(en), .i_a(m_pay), .i_b(m_dx),  .o_p(p_ydx));
    cshit_mul #(.AW(RAD_W), .BW(RAD_W)) u_r2 (.i_clk, .i_en(en), .i_a(r_rad), .i_b(r_rad),
                                              .o_p(r2_m));
    cshit_mul #(.AW(TOL_W), .BW(TOL_W)) u_t2 (.i_clk, .i_en(en), .i_a(r_tol), .i_b(r_tol),
                                              .o_p(t2_m));

    assign sb1_in = {r_v0, r_pax[DW-1] ^ r_dx[DW-1], r_pay[DW-1] ^ r_dy[DW-1],
                     r_pax[DW-1] ^ r_dy[DW-1], r_pay[DW-1] ^ r_dx[DW-1]};
    cshit_dly #(.W(5), .L(MUL_LAT)) u_sb1 (.i_clk, .i_rst_n, .i_en(en), .i_d(sb1_in),
                                           .o_d(sb1_out));

    // ---------------- stage B: sums
    logic signed [DOT_W-1:0] t_xdx, t_ydy, t_xdy, t_ydx;
    logic r_vb;
    logic [SUM_W-1:0] r_e1, r_e2, r_l2;
    logic [R2_W-1:0] r_r2b;
    logic [T2_W-1:0] r_t2b;
    logic signed [DOT_W-1:0] r_dot, r_cross;

    assign t_xdx = sb1_out[3] ? -DOT_W'(p_xdx) : DOT_W'(p_xdx);
    assign t_ydy = sb1_out[2] ? -DOT_W'(p_ydy) : DOT_W'(p_ydy);
    assign t_xdy = sb1_out[1] ? -DOT_W'(p_xdy) : DOT_W'(p_xdy);
    assign t_ydx = sb1_out[0] ? -DOT_W'(p_ydx) : DOT_W'(p_ydx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (en) begin
            r_vb <= sb1_out[4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e1    <= SUM_W'(sq_pax) + SUM_W'(sq_pay);
            r_e2    <= SUM_W'(sq_pbx) + SUM_W'(sq_pby);
            r_l2    <= SUM_W'(sq_dx) + SUM_W'(sq_dy);
            r_dot   <= t_xdx + t_ydy;
            r_cross <= t_xdy - t_ydx;
            r_r2b   <= r2_m;
            r_t2b   <= t2_m;
        end
    end

    // ---------------- stage C: endpoint test, overshoot past the ends
    logic r_vc, r_ehit, r_l2z;
    logic [SUM_W-1:0] r_over, r_acr, r_l2c;
    logic [R2_W-1:0] r_r2c;
    logic [T2_W-1:0] r_t2c;
    logic [SUM_W-1:0] n_over;

    always_comb begin
        priority if (r_dot[DOT_W-1]) begin
            n_over = SUM_W'(-r_dot);
        end else if (DOT_W'(r_dot) > DOT_W'(r_l2)) begin
            n_over = SUM_W'(r_dot - $signed(DOT_W'(r_l2)));
        end else begin
            n_over = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
        end else if (en) begin
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ehit <= (r_e1 <= SUM_W'(r_r2b)) || (r_e2 <= SUM_W'(r_r2b));
            r_l2z  <= (r_l2 == '0);
            r_over <= n_over;
            r_acr  <= r_cross[DOT_W-1] ? SUM_W'(-r_cross) : SUM_W'(r_cross);
            r_l2c  <= r_l2;
            r_r2c  <= r_r2b;
            r_t2c  <= r_t2b;
        end
    end

    // ---------------- bank 2
    localparam int OV2_W = 2 * SUM_W;
    localparam int TL_W  = T2_W + SUM_W;
    localparam int RL_W  = R2_W + SUM_W;
    localparam int CMP_W = OV2_W + 2;

    logic [OV2_W-1:0] over2, cross2;
    logic [TL_W-1:0]  tl2;
    logic [RL_W-1:0]  rl2;
    logic [3:0] sb2_in, sb2_out;

    cshit_mul #(.AW(SUM_W), .BW(SUM_W)) u_ov2 (.i_clk, .i_en(en), .i_a(r_over), .i_b(r_over),
                                               .o_p(over2));
    cshit_mul #(.AW(SUM_W), .BW(SUM_W)) u_cr2 (.i_clk, .i_en(en), .i_a(r_acr), .i_b(r_acr),
                                               .o_p(cross2));
    cshit_mul #(.AW(T2_W), .BW(SUM_W)) u_tl2 (.i_clk, .i_en(en), .i_a(r_t2c), .i_b(r_l2c),
                                              .o_p(tl2));
    cshit_mul #(.AW(R2_W), .BW(SUM_W)) u_rl2 (.i_clk, .i_en(en), .i_a(r_r2c), .i_b(r_l2c),
                                              .o_p(rl2));

    assign sb2_in = {r_vc, r_ehit, r_l2z, r_over == '0};
    cshit_dly #(.W(4), .L(MUL_LAT)) u_sb2 (.i_clk, .i_rst_n, .i_en(en), .i_d(sb2_in),
                                           .o_d(sb2_out));

    // ---------------- stage D: final compare into output register
    logic on_seg, proj_in;
    logic r_out_v, r_hit;

    // 4*over^2 <= tol^2 * L2
    assign on_seg  = sb2_out[0] || ({over2, 2'b00} <= CMP_W'(tl2));
    assign proj_in = cross2 <= OV2_W'(rl2);

    assign en = !r_out_v || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= sb2_out[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit <= sb2_out[2] || (!sb2_out[1] && on_seg && proj_in);
        end
    end

    assign s_axis_tready = en;
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = OUT_W'(r_hit);

    // ---------------- assertions
    a_stall_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while output stalled");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_v0)
        else $error("accepted beat lost at stage 0");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |=> ($stable(r_vb) && $stable(r_vc)))
        else $error("pipeline moved during stall");
endmodule
`default_nettype wire

### tb/circle_segment_hit_test_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_segment_hit_test_core_test
// Streams circle / segment queries through the core and compares each hit
// beat with an exact integer prediction, under random gaps and stalls.
// ----------------------------------------------------------------------------
module circle_segment_hit_test_core_test;
    import cshit_pkg::*;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [OUT_W-1:0]     m_axis_tdata;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [TOL_W-1:0]     i_cfg_data;

    typedef struct {
        logic signed [31:0] ax, ay, bx, by, cx, cy;
        logic [30:0]        rad;
    } t_query;

    logic [15:0] tol_shadow;
    logic        hits_due[$];
    int          mismatch_cnt;
    bit          hold_rx;
    int          hold_cycles;

    circle_segment_hit_test_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // exact squared-distance form; 260 bits covers every product
    function automatic logic predict_hit(t_query q, logic [15:0] tol);
        logic signed [259:0] pax, pay, pbx, pby, dx, dy, r2, l2, dot, ovr, crs;
        logic signed [259:0] lhs, rhs;
        pax = 260'(signed'(q.cx)) - 260'(signed'(q.ax));
        pay = 260'(signed'(q.cy)) - 260'(signed'(q.ay));
        pbx = 260'(signed'(q.cx)) - 260'(signed'(q.bx));
        pby = 260'(signed'(q.cy)) - 260'(signed'(q.by));
        dx  = 260'(signed'(q.bx)) - 260'(signed'(q.ax));
        dy  = 260'(signed'(q.by)) - 260'(signed'(q.ay));
        r2 = 260'(q.rad) * 260'(q.rad);
        if (pax * pax + pay * pay <= r2) return 1'b1;
        if (pbx * pbx + pby * pby <= r2) return 1'b1;
        l2 = dx * dx + dy * dy;
        if (l2 == 0) return 1'b0;
        dot = pax * dx + pay * dy;
        if (dot < 0) ovr = -dot;
        else if (dot > l2) ovr = dot - l2;
        else ovr = 0;
        if (ovr != 0) begin
            lhs = 4 * ovr * ovr;
            rhs = 260'(tol) * 260'(tol) * l2;
            if (lhs > rhs) return 1'b0;
        end
        crs = pax * dy - pay * dx;
        return (crs * crs <= r2 * l2);
    endfunction

    // valid drops right after the accepting edge; a gap of zero raises it again
    // in the same step, so the beats stay back to back
    task automatic send_query(t_query q);
        int gap;
        gap = $urandom_range(0, 4);
        repeat (gap) @(negedge i_clk);
        s_axis_tdata  <= {1'b0, q.rad, q.cy, q.cx, q.by, q.bx, q.ay, q.ax};
        s_axis_tvalid <= 1'b1;
        hits_due.push_back(predict_hit(q, tol_shadow));
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic drain_results();
        while (hits_due.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_tolerance(logic [15:0] v);
        drain_results();
        i_cfg_data  <= v;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        tol_shadow = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
            default: return 32'($signed($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    // random query; mostly near-segment circles so all branches get exercised
    function automatic t_query rand_query();
        t_query q;
        int     m;
        int     t;
        m = $urandom_range(0, 9);
        if (m == 0) begin
            q.ax = $urandom(); q.ay = $urandom(); q.bx = $urandom();
            q.by = $urandom(); q.cx = $urandom(); q.cy = $urandom();
            q.rad = 31'($urandom());
        end else begin
            t = (m < 8) ? 1 : 2;
            q.ax = rand_coord(t); q.ay = rand_coord(t);
            q.bx = rand_coord(t); q.by = rand_coord(t);
            if ($urandom_range(0, 9) == 0) begin
                q.bx = q.ax; q.by = q.ay;
            end
            // centre near a point along the line, beyond the ends at times
            t = $urandom_range(0, 1400) - 200;
            q.cx = q.ax + 32'((64'(signed'(q.bx - q.ax)) * t) / 1000)
                   + rand_coord(2) * (m < 5 ? 256 : 1);
            q.cy = q.ay + 32'((64'(signed'(q.by - q.ay)) * t) / 1000)
                   + rand_coord(2) * (m < 5 ? 256 : 1);
            q.rad = (m < 8) ? 31'($urandom_range(0, 4 << 16)) : 31'($urandom_range(0, 3000));
        end
        return q;
    endfunction

    function automatic t_query mk(int ax, int ay, int bx, int by, int cx, int cy, int r);
        t_query q;
        q.ax = ax; q.ay = ay; q.bx = bx; q.by = by; q.cx = cx; q.cy = cy; q.rad = 31'(r);
        return q;
    endfunction

    task automatic test_directed();
        send_query(mk(0, 0, 10 << 16, 0, 0, 0, 0));              // endpoint on centre
        send_query(mk(0, 0, 10 << 16, 0, 10 << 16, 1 << 16, 1 << 16)); // touches B
        send_query(mk(0, 0, 10 << 16, 0, 5 << 16, 1 << 16, 1 << 16));  // tangent mid
        send_query(mk(0, 0, 10 << 16, 0, 5 << 16, 2 << 16, 1 << 16));  // miss mid
        send_query(mk(0, 0, 10 << 16, 0, -3 << 16, 0, 1 << 16));       // beyond A
        send_query(mk(0, 0, 10 << 16, 0, 11 << 16, 1 << 16, 1 << 16)); // beyond B
        send_query(mk(3 << 16, 3 << 16, 3 << 16, 3 << 16, 0, 0, 1 << 16)); // zero length
        send_query(mk(3 << 16, 3 << 16, 3 << 16, 3 << 16, 3 << 16, 3 << 16, 0));
        send_query(mk(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
                      0, 0, 31'h7FFFFFFF));
        send_query(mk(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                      32'h80000000, 32'h80000000, 0));
        send_query(mk(32'h80000000, 0, 32'h7FFFFFFF, 0, 0, 32'h7FFFFFFF, 31'h7FFFFFFF));
        send_query(mk(-1, -1, -1, -1, -1, -1, 31'h7FFFFFFF));
        send_query(mk(0, 0, 1 << 16, 0, (1 << 16) + 3277, 100, 200)); // inside slack
        send_query(mk(0, 0, 1 << 16, 0, -3277, 100, 200));
    endtask

    task automatic test_random(int n);
        repeat (n) send_query(rand_query());
    endtask

    task automatic test_backpressure();
        hold_cycles = 200;
        hold_rx     = 1'b1;
        repeat (40) send_query(rand_query());
        drain_results();  // sender pauses until all results are in
    endtask

    task automatic test_tolerance_sweep();
        write_tolerance(16'd0);
        test_directed();
        test_random(250);
        write_tolerance(16'hFFFF);
        test_directed();
        test_random(250);
        write_tolerance(16'($urandom()));
        test_random(250);
        write_tolerance(TOL_RST);
    endtask

    // receiver: random stalls, or one long hold-off on request
    initial begin
        int w;
        m_axis_tready = 1'b0;
        hold_rx = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_rx) begin
                m_axis_tready <= 1'b0;
                repeat (hold_cycles) @(negedge i_clk);
                hold_rx = 1'b0;
            end
            w = $urandom_range(0, 4);
            if ($urandom_range(0, 3) == 0) w = 0;
            m_axis_tready <= (w == 0);
            if (w != 0) begin
                repeat (w - 1) @(negedge i_clk);
            end
        end
    end

    // result checker
    initial begin
        logic exp_hit;
        mismatch_cnt = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                if (hits_due.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) $display("unexpected hit beat %0d", m_axis_tdata[0]);
                end else begin
                    exp_hit = hits_due.pop_front();
                    if (m_axis_tdata[0] !== exp_hit) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("hit mismatch: expected %0d actual %0d", exp_hit,
                                     m_axis_tdata[0]);
                    end
                end
            end
        end
    end

    initial begin
        #50ms;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        tol_shadow    = TOL_RST;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(300);
        test_backpressure();
        test_tolerance_sweep();
        test_random(300);
        drain_results();
        if (mismatch_cnt == 0 && hits_due.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

### circle_segment_hit_test_core.f
rtl/core/cshit_pkg.sv
rtl/core/cshit_mul.sv
rtl/core/cshit_dly.sv
rtl/core/circle_segment_hit_test_core.sv
tb/circle_segment_hit_test_core_test.sv
